// ===== hdl/sqet_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sqet_pkg
// Shared types and constants for the shell quote and escape tokenizer.
// ----------------------------------------------------------------------------
package sqet_pkg;

	localparam int COUNT_BITS_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] TOKEN_LIMIT_RESET = 8'd16;

	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BACKSLASH = 2'd1;
	localparam logic [1:0] ST_TOO_MANY  = 2'd2;
	localparam logic [1:0] ST_QUOTE     = 2'd3;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_SINGLE = 2'd1,
		Q_DOUBLE = 2'd2
	} quote_mode_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       line_end;
	} char_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       token_end;
		logic [7:0] token_index;
		logic       line_done;
		logic [1:0] status;
		logic [7:0] token_count;
	} res_item_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       line_end;
		logic       blank;
		logic       bslash;
		logic       dquote;
		logic       squote;
	} char_class_t;

endpackage
`default_nettype wire

// ===== hdl/sqet_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sqet_front
// Input side: takes bytes and classifies them for the token engine.
// ----------------------------------------------------------------------------
module sqet_front (
	input  wire                     char_valid,
	output logic                    char_stall,
	input  wire sqet_pkg::char_item_t char_item,
	input  wire                     queue_full,
	output logic                    push,
	output sqet_pkg::char_class_t   entry
);
	import sqet_pkg::*;

	logic [7:0] c;

	assign c          = char_item.char_byte;
	assign char_stall = queue_full;
	assign push       = char_valid & ~queue_full;

	always_comb begin
		entry.char_byte = c;
		entry.line_end  = char_item.line_end;
		entry.blank     = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		entry.bslash    = (c == CH_BACKSLASH);
		entry.dquote    = (c == CH_DQUOTE);
		entry.squote    = (c == CH_SQUOTE);
	end

endmodule
`default_nettype wire

// ===== hdl/sqet_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sqet_queue
// Short register queue between the classifier and the token engine.
// ----------------------------------------------------------------------------
module sqet_queue #(
	parameter int DEPTH = sqet_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire sqet_pkg::char_class_t wdata,
	input  wire                      pop,
	output sqet_pkg::char_class_t    rdata,
	output logic                     not_empty,
	output logic                     full
);
	import sqet_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	char_class_t   entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));
	assign rdata     = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance");

endmodule
`default_nettype wire

// ===== hdl/sqet_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sqet_back
// Token engine: quote, escape and token state, result register.
// ----------------------------------------------------------------------------
module sqet_back #(
	parameter int COUNT_BITS = sqet_pkg::COUNT_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire [7:0]                token_limit,
	input  wire sqet_pkg::char_class_t entry,
	input  wire                      entry_valid,
	output logic                     pop,
	output logic                     res_valid,
	input  wire                      res_stall,
	output sqet_pkg::res_item_t      res_item
);
	import sqet_pkg::*;

	localparam int LW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam logic [LW-1:0] CMAX = LW'((32'd1 << COUNT_BITS) - 32'd1);

	quote_mode_t           quote_q, quote_d;
	logic                  esc_q, esc_d;
	logic                  in_tok_q, in_tok_d;
	logic [COUNT_BITS-1:0] seen_q, seen_d;
	logic [1:0]            err_q, err_d;

	logic                  out_free;
	logic                  emit;
	res_item_t             res_d;
	res_item_t             res_q;
	logic                  res_valid_q;
	logic [LW-1:0]         lim_w;
	logic [LW-1:0]         lim_eff;
	logic [COUNT_BITS-1:0] cur_idx;
	logic [1:0]            st;
	logic                  is_close;

	assign out_free  = ~res_valid_q | ~res_stall;
	assign pop       = entry_valid & out_free;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	assign lim_w   = LW'(token_limit);
	assign lim_eff = (lim_w > CMAX) ? CMAX : lim_w;

	always_comb begin
		quote_d  = quote_q;
		esc_d    = esc_q;
		in_tok_d = in_tok_q;
		seen_d   = seen_q;
		err_d    = err_q;
		emit     = 1'b0;
		res_d    = '0;
		st       = err_q;
		cur_idx  = '0;
		is_close = 1'b0;

		if (entry.line_end) begin
			if (st == ST_OK && esc_q) begin
				st = ST_BACKSLASH;
			end
			if (st == ST_OK && quote_q != Q_NONE) begin
				st = ST_QUOTE;
			end
			emit            = 1'b1;
			res_d.line_done = 1'b1;
			res_d.status    = st;
			if (st == ST_OK) begin
				cur_idx           = seen_q - 1'b1;
				res_d.token_end   = in_tok_q;
				res_d.token_index = in_tok_q ? 8'(cur_idx) : 8'd0;
				res_d.token_count = 8'(seen_q);
			end
			quote_d  = Q_NONE;
			esc_d    = 1'b0;
			in_tok_d = 1'b0;
			seen_d   = '0;
			err_d    = ST_OK;
		end else if (err_q != ST_OK) begin
			emit = 1'b0;
		end else if (esc_q) begin
			esc_d             = 1'b0;
			cur_idx           = seen_q - 1'b1;
			emit              = 1'b1;
			res_d.out_byte    = entry.char_byte;
			res_d.byte_valid  = 1'b1;
			res_d.token_index = 8'(cur_idx);
		end else if (!in_tok_q && entry.blank) begin
			emit = 1'b0;
		end else if (!in_tok_q && (LW'(seen_q) >= lim_eff)) begin
			err_d = ST_TOO_MANY;
		end else if (in_tok_q && quote_q == Q_NONE && entry.blank) begin
			in_tok_d          = 1'b0;
			cur_idx           = seen_q - 1'b1;
			emit              = 1'b1;
			res_d.token_end   = 1'b1;
			res_d.token_index = 8'(cur_idx);
		end else begin
			if (!in_tok_q) begin
				seen_d   = seen_q + 1'b1;
				in_tok_d = 1'b1;
			end
			cur_idx  = seen_d - 1'b1;
			is_close = (quote_q == Q_DOUBLE && entry.dquote) ||
			           (quote_q == Q_SINGLE && entry.squote);
			if (entry.bslash && quote_q != Q_SINGLE) begin
				esc_d = 1'b1;
			end else if (quote_q == Q_NONE && entry.dquote) begin
				quote_d = Q_DOUBLE;
			end else if (quote_q == Q_NONE && entry.squote) begin
				quote_d = Q_SINGLE;
			end else if (is_close) begin
				quote_d = Q_NONE;
			end else begin
				emit              = 1'b1;
				res_d.out_byte    = entry.char_byte;
				res_d.byte_valid  = 1'b1;
				res_d.token_index = 8'(cur_idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q     <= Q_NONE;
			esc_q       <= 1'b0;
			in_tok_q    <= 1'b0;
			seen_q      <= '0;
			err_q       <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				quote_q  <= quote_d;
				esc_q    <= esc_d;
				in_tok_q <= in_tok_d;
				seen_q   <= seen_d;
				err_q    <= err_d;
			end
			if (out_free) begin
				res_valid_q <= pop & emit;
			end
		end
	end

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && entry.line_end) |=> (seen_q == '0 && err_q == ST_OK &&
		quote_q == Q_NONE && !esc_q && !in_tok_q))
		else $error("line state not cleared at line end");

	a_err_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.line_done && res_q.status != ST_OK) |->
		(res_q.token_count == 8'd0 && !res_q.token_end))
		else $error("error result carries a count");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && err_q != ST_OK && !entry.line_end) |-> !emit)
		else $error("result emitted after a latched error");

	a_byte_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.byte_valid) |->
		(!res_q.line_done && !res_q.token_end))
		else $error("byte result marked as end");

endmodule
`default_nettype wire

// ===== hdl/shell_quote_escape_tokenizer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shell_quote_escape_tokenizer_core
// Shell-style word splitter with quotes, backslash escape and token limit.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and gives at most one result per
// byte, so a steady stream runs at one byte per cycle when the result side
// does not stall. A byte passes a classifier, a QUEUE_DEPTH-entry queue and
// the token engine, whose result register is the output: a byte is held in
// its queue entry and its result then in the result register. The token
// engine updates its state once per byte, and that state update sets the
// rate. token_limit lies at byte address 0 of the register port; the user
// must write it between lines only, as the block itself does not enforce it.
module shell_quote_escape_tokenizer_core #(
	parameter int COUNT_BITS  = sqet_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = sqet_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire [2:0]                 paddr,
	input  wire [31:0]                pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire                       char_valid,
	output logic                      char_stall,
	input  wire sqet_pkg::char_item_t char_item,
	output logic                      res_valid,
	input  wire                       res_stall,
	output sqet_pkg::res_item_t       res_item
);
	import sqet_pkg::*;

	logic [7:0]  token_limit_q;
	logic        push;
	logic        pop;
	logic        queue_full;
	logic        queue_ne;
	char_class_t entry_in;
	char_class_t entry_out;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {24'd0, token_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_limit_q <= TOKEN_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			token_limit_q <= pwdata[7:0];
		end
	end

	sqet_front u_front (
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.queue_full (queue_full),
		.push       (push),
		.entry      (entry_in)
	);

	sqet_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (entry_in),
		.pop       (pop),
		.rdata     (entry_out),
		.not_empty (queue_ne),
		.full      (queue_full)
	);

	sqet_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.token_limit (token_limit_q),
		.entry       (entry_out),
		.entry_valid (queue_ne),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_item    (res_item)
	);

endmodule
`default_nettype wire
